// File: hw/rtl/tsr_pkg.sv
// Package for the row-wise top-k selector: field widths, defaults and control structs.
`default_nettype none

package tsr_pkg;

  // Widths fixed by the transaction fields.
  localparam int SCORE_W = 32;
  localparam int POS_W_PORT = 18;
  localparam int RANK_W = 4;
  localparam int K_W = 5;

  // Configuration register map and reset value.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_IDX_K = 1'b0;
  localparam logic [K_W-1:0] K_RESET = 5'd10;

  // Default sizing of the selector.
  localparam int K_MAX_DEF = 16;
  localparam int ROW_MAX_DEF = 262144;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;   // take the input score into the list
    logic end_row;  // the inserted score closes the row
    logic shift;    // the head entry was delivered, move the list up
  } tsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;     // the head entry is the final one of the row
  } tsr_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/topk_select_row.sv
// Top level of the streaming row-wise top-k selector with its register port.
// Latency: the first result of a row is offered in the cycle after the row_end
// transaction, then one result per cycle while out_stall is low.
// Throughput: one score per cycle within a row; a row of n kept entries is then
// emitted from the head of the insertion list, input stalled.
// Reset: control state, counters and k (to 10) are cleared; list contents are not.
`default_nettype none

module topk_select_row
  import tsr_pkg::*;
#(
  parameter int K_MAX = K_MAX_DEF,
  parameter int ROW_MAX = ROW_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic        [ADDR_W-1:0]     paddr,
  input  wire logic        [DATA_W-1:0]     pwdata,
  output logic             [DATA_W-1:0]     prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [SCORE_W-1:0]    score,
  input  wire logic                         row_end,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [POS_W_PORT-1:0] position,
  output logic signed      [SCORE_W-1:0]    best_score,
  output logic             [RANK_W-1:0]     rank,
  output logic                              last_of_run
);

  logic [K_W-1:0] k;
  tsr_cmd_t       cmd;
  tsr_status_t    status;

  // Register port: one writable register, no wait states.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_K) ? DATA_W'(k) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= K_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_K)) begin
      k <= pwdata[K_W-1:0];
    end
  end

  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .row_end   (row_end),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  tsr_datapath #(
    .K_MAX   (K_MAX),
    .ROW_MAX (ROW_MAX)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .k          (k),
    .cmd        (cmd),
    .score      (score),
    .status     (status),
    .position   (position),
    .best_score (best_score),
    .rank       (rank)
  );

  assign last_of_run = status.last;

`ifndef ASSERT_OFF
  // The last result of a row returns the block to taking scores.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_of_run |=> !out_valid)
    else $error("emission did not end after the last result");

  // A row_end transaction starts emission at rank zero.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && row_end |=> out_valid && rank == '0)
    else $error("emission did not start at rank zero");

  // Ranks within a row climb by one per delivered result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=>
      out_valid && rank == RANK_W'($past(rank) + 1'b1))
    else $error("rank did not advance by one");

  // Scores are never taken while results are on offer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during emission");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/tsr_ctrl.sv
// Controller state machine of the top-k selector: fill phase and emission phase.
`default_nettype none

module tsr_ctrl
  import tsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        row_end,
  input  wire logic        out_stall,
  input  tsr_status_t      status,
  output tsr_cmd_t         cmd,
  output logic             in_stall,
  output logic             out_valid
);

  typedef enum logic {
    S_FILL,
    S_EMIT
  } state_t;

  state_t state;
  logic   in_take;
  logic   out_take;

  // Input is taken only while filling; results leave only while emitting.
  assign in_stall  = (state == S_EMIT);
  assign out_valid = (state == S_EMIT);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  assign cmd.insert  = in_take;
  assign cmd.end_row = in_take && row_end;
  assign cmd.shift   = out_take;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      unique case (state)
        S_FILL: begin
          if (in_take && row_end) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_take && status.last) begin
            state <= S_FILL;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tsr_datapath.sv
// Datapath of the top-k selector: sorted insertion list, counters and result head.
`default_nettype none

module tsr_datapath
  import tsr_pkg::*;
#(
  parameter int K_MAX = K_MAX_DEF,
  parameter int ROW_MAX = ROW_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic        [K_W-1:0]       k,
  input  tsr_cmd_t                         cmd,
  input  wire logic signed [SCORE_W-1:0]   score,
  output tsr_status_t                      status,
  output logic             [POS_W_PORT-1:0] position,
  output logic signed      [SCORE_W-1:0]   best_score,
  output logic             [RANK_W-1:0]    rank
);

  localparam int CNT_W = $clog2(K_MAX + 1);
  localparam int POS_W = $clog2(ROW_MAX);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(ROW_MAX - 1);

  logic signed [SCORE_W-1:0]    kept_scores [K_MAX];
  logic        [POS_W_PORT-1:0] kept_positions [K_MAX];
  logic signed [SCORE_W-1:0]    kept_scores_next [K_MAX];
  logic        [POS_W_PORT-1:0] kept_positions_next [K_MAX];
  logic        [CNT_W-1:0]      filled;
  logic        [CNT_W-1:0]      emit_count;
  logic        [CNT_W-1:0]      rank_cnt;
  logic        [POS_W-1:0]      element_counter;

  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] filled_eff;
  logic [CNT_W-1:0] filled_ins;
  logic [K_MAX-1:0] ge;
  logic [K_MAX-1:0] prev_ge;

  // Effective list length: zero acts as one, values above the capacity clamp.
  always_comb begin
    if (k == '0) begin
      lim = CNT_W'(1);
    end else if (32'(k) > K_MAX) begin
      lim = CNT_W'(K_MAX);
    end else begin
      lim = CNT_W'(k);
    end
  end

  // The list is cut to the current length before the insertion.
  assign filled_eff = (filled > lim) ? lim : filled;
  assign filled_ins = (filled_eff < lim) ? CNT_W'(filled_eff + 1'b1) : filled_eff;

  // Every entry compares itself with the new score; ties keep the older entry ahead.
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      ge[i] = (CNT_W'(i) < filled_eff) && (kept_scores[i] >= score);
    end
    prev_ge[0] = 1'b1;
    for (int i = 1; i < K_MAX; i++) begin
      prev_ge[i] = ge[i-1];
    end
  end

  // Next list contents: insert in place, or move up by one after a delivered result.
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      kept_scores_next[i]    = kept_scores[i];
      kept_positions_next[i] = kept_positions[i];
    end
    if (cmd.insert) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (!ge[i] && prev_ge[i]) begin
          kept_scores_next[i]    = score;
          kept_positions_next[i] = POS_W_PORT'(element_counter);
        end
      end
      for (int i = 1; i < K_MAX; i++) begin
        if (!prev_ge[i]) begin
          kept_scores_next[i]    = kept_scores[i-1];
          kept_positions_next[i] = kept_positions[i-1];
        end
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < K_MAX - 1; i++) begin
        kept_scores_next[i]    = kept_scores[i+1];
        kept_positions_next[i] = kept_positions[i+1];
      end
    end
  end

  // List storage; its contents beyond the fill count are never read.
  always_ff @(posedge clk) begin
    for (int i = 0; i < K_MAX; i++) begin
      kept_scores[i]    <= kept_scores_next[i];
      kept_positions[i] <= kept_positions_next[i];
    end
  end

  // Fill count, position counter and emission counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled          <= '0;
      element_counter <= '0;
      emit_count      <= '0;
      rank_cnt        <= '0;
    end else begin
      if (cmd.insert) begin
        if (cmd.end_row) begin
          filled          <= '0;
          element_counter <= '0;
          emit_count      <= filled_ins;
          rank_cnt        <= '0;
        end else begin
          filled <= filled_ins;
          if (element_counter != POS_LAST) begin
            element_counter <= element_counter + 1'b1;
          end
        end
      end else if (cmd.shift) begin
        rank_cnt <= rank_cnt + 1'b1;
      end
    end
  end

  // The head of the list is the result on offer.
  assign position    = kept_positions[0];
  assign best_score  = kept_scores[0];
  assign rank        = RANK_W'(rank_cnt);
  assign status.last = (CNT_W'(rank_cnt + 1'b1) == emit_count);

endmodule

`default_nettype wire

// File: dv/tb_topk_select_row.sv
// Self-checking testbench for the streaming row-wise top-k selector.
`default_nettype none

module tb_topk_select_row;
  import tsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int K_MAX = K_MAX_DEF;
  localparam int ROW_MAX = ROW_MAX_DEF;
  // Register index that maps to no register.
  localparam int REG_IDX_NONE = 1;
  // Cycles of quiet after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES = 6;
  // Leave wide headroom over the slowest correct run.
  localparam int CYCLE_LIMIT = 200_000;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;

  // One emitted entry of a row.
  typedef struct {
    logic [POS_W_PORT-1:0]     position;
    logic signed [SCORE_W-1:0] score;
    logic [RANK_W-1:0]         rank;
    logic                      last;
  } ranked_entry_t;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic        [ADDR_W-1:0]     paddr;
  logic        [DATA_W-1:0]     pwdata;
  logic        [DATA_W-1:0]     prdata;
  logic                         pready;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [SCORE_W-1:0]    score;
  logic                         row_end;
  logic                         out_valid;
  logic                         out_stall;
  logic        [POS_W_PORT-1:0] position;
  logic signed [SCORE_W-1:0]    best_score;
  logic        [RANK_W-1:0]     rank;
  logic                         last_of_run;

  // Predictor state: the sorted list, its fill level, the position counter and k.
  logic signed [SCORE_W-1:0] kept_score [K_MAX];
  logic [POS_W_PORT-1:0]     kept_pos [K_MAX];
  int                        kept_count;
  int                        next_pos;
  logic [K_W-1:0]            cur_k;

  ranked_entry_t expected_ranked[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct;
  int            recv_idle_pct;

  topk_select_row #(
    .K_MAX  (K_MAX),
    .ROW_MAX(ROW_MAX)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .score      (score),
    .row_end    (row_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .position   (position),
    .best_score (best_score),
    .rank       (rank),
    .last_of_run(last_of_run)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run time guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d entries still expected", $time, expected_ranked.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare every accepted result transaction with the oldest predicted entry.
  always @(posedge clk) begin : check_results
    ranked_entry_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ranked.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, actual pos %0d score %0d rank %0d last %0b",
                 $time, position, best_score, rank, last_of_run);
      end else begin
        want = expected_ranked.pop_front();
        if (position !== want.position) begin
          mismatch_count++;
          $display("%0t: position mismatch: expected %0d, actual %0d",
                   $time, want.position, position);
        end
        if (best_score !== want.score) begin
          mismatch_count++;
          $display("%0t: best_score mismatch: expected %0d, actual %0d",
                   $time, want.score, best_score);
        end
        if (rank !== want.rank) begin
          mismatch_count++;
          $display("%0t: rank mismatch: expected %0d, actual %0d", $time, want.rank, rank);
        end
        if (last_of_run !== want.last) begin
          mismatch_count++;
          $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                   $time, want.last, last_of_run);
        end
      end
    end
  end

  // Place a score into the sorted list; equal scores stay behind earlier ones.
  task automatic rank_insert(input logic signed [SCORE_W-1:0] s,
                             input logic [POS_W_PORT-1:0] pos, input int lim);
    int at;
    int i;
    at = 0;
    if (kept_count > lim) kept_count = lim;
    while (at < kept_count && kept_score[at] >= s) at++;
    if (at < lim) begin
      i = (kept_count < lim) ? kept_count : lim - 1;
      while (i > at) begin
        kept_score[i] = kept_score[i-1];
        kept_pos[i] = kept_pos[i-1];
        i--;
      end
      kept_score[at] = s;
      kept_pos[at] = pos;
      if (kept_count < lim) kept_count++;
    end
  endtask

  // Update the predictor with one accepted score and queue the row's entries at row end.
  task automatic predict_score(input logic signed [SCORE_W-1:0] s, input logic last);
    int lim;
    int n;
    logic [POS_W_PORT-1:0] pos;
    ranked_entry_t e;
    if (cur_k == 0) lim = 1;
    else if (int'(cur_k) > K_MAX) lim = K_MAX;
    else lim = int'(cur_k);
    pos = next_pos[POS_W_PORT-1:0];
    if (next_pos < ROW_MAX - 1) next_pos++;
    rank_insert(s, pos, lim);
    if (last) begin
      n = (kept_count < lim) ? kept_count : lim;
      for (int r = 0; r < n; r++) begin
        e.position = kept_pos[r];
        e.score = kept_score[r];
        e.rank = r[RANK_W-1:0];
        e.last = (r + 1 == n);
        expected_ranked.insert(expected_ranked.size(), e);
      end
      kept_count = 0;
      next_pos = 0;
    end
  endtask

  // Send one score transaction, with random idle cycles ahead of it.
  task automatic send_score(input logic signed [SCORE_W-1:0] s, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    score <= s;
    row_end <= last;
    do @(posedge clk); while (in_stall);
    predict_score(s, last);
    @(negedge clk);
  endtask

  // Stop the score stream and wait until every predicted entry has come out.
  task automatic settle_block();
    in_valid <= 1'b0;
    row_end <= 1'b0;
    while (expected_ranked.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write through the setup and access phases.
  task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == int'(REG_IDX_K)) cur_k = value[K_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Random score: extremes, a narrow band that produces ties, or any value.
  function automatic logic signed [SCORE_W-1:0] pick_score();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return SCORE_MIN;
      1: return SCORE_MAX;
      2, 3, 4: return $urandom_range(8) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Random k value, mostly small, sometimes out of range or with high bits set.
  function automatic logic [DATA_W-1:0] pick_k();
    logic [DATA_W-1:0] v;
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: v = 0;
      1: v = K_MAX;
      2: v = $urandom_range(K_MAX + 1, 31);
      3: v = 1;
      default: v = $urandom_range(2, 8);
    endcase
    if ($urandom_range(3) == 0) v = ($urandom & ~32'h1F) | v[K_W-1:0];
    return v;
  endfunction

  // Reset value of k, extreme scores and ties in one row.
  task automatic test_default_k();
    logic signed [SCORE_W-1:0] row_scores [12];
    row_scores = '{SCORE_MAX, SCORE_MIN, 0, -1, 1, 5, 5, SCORE_MAX, SCORE_MIN, 3, 5, -1};
    for (int i = 0; i < 12; i++) send_score(row_scores[i], i == 11);
    settle_block();
  endtask

  // Rows shorter than k, down to a single element.
  task automatic test_short_rows();
    write_reg(REG_IDX_K, K_MAX);
    send_score(7, 1'b0);
    send_score(-7, 1'b0);
    send_score(7, 1'b1);
    send_score(SCORE_MIN, 1'b1);
    settle_block();
  endtask

  // k of zero, k above the maximum, masked data bits and a write to no register.
  task automatic test_k_limits();
    write_reg(REG_IDX_K, 0);
    send_score(2, 1'b0);
    send_score(9, 1'b0);
    send_score(4, 1'b1);
    settle_block();
    write_reg(REG_IDX_K, 31);
    send_score(SCORE_MIN, 1'b0);
    send_score(SCORE_MAX, 1'b1);
    settle_block();
    write_reg(REG_IDX_K, 32'hFFFF_FFE3);
    send_score(1, 1'b0);
    send_score(2, 1'b1);
    settle_block();
    write_reg(REG_IDX_NONE, 32'h0000_0001);
    send_score(3, 1'b0);
    send_score(1, 1'b0);
    send_score(4, 1'b0);
    send_score(2, 1'b1);
    settle_block();
  endtask

  // Lowering k in the middle of a row cuts the list before the next insertion.
  task automatic test_k_lowered_mid_row();
    write_reg(REG_IDX_K, 8);
    send_score(10, 1'b0);
    send_score(30, 1'b0);
    send_score(20, 1'b0);
    send_score(50, 1'b0);
    send_score(40, 1'b0);
    settle_block();
    write_reg(REG_IDX_K, 2);
    send_score(35, 1'b0);
    send_score(60, 1'b1);
    settle_block();
  endtask

  // Random rows with random k between rows and now and then inside a row.
  task automatic test_random_rows(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        settle_block();
        if ($urandom_range(7) == 0) write_reg(REG_IDX_NONE, $urandom);
        write_reg(REG_IDX_K, pick_k());
      end
      len = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      for (int i = 0; i < len; i++) begin
        if (i == len / 2 && len > 2 && $urandom_range(7) == 0) begin
          settle_block();
          write_reg(REG_IDX_K, pick_k());
        end
        send_score(pick_score(), i == len - 1);
      end
      sent += len;
    end
    settle_block();
  endtask

  // Test sequence.
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    score = '0;
    row_end = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 62;
    kept_count = 0;
    next_pos = 0;
    cur_k = K_RESET;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);

    test_default_k();
    test_short_rows();
    test_k_limits();
    test_k_lowered_mid_row();
    test_random_rows(90);

    send_idle_pct = 62;
    recv_idle_pct = 15;
    test_random_rows(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_rows(85);

    settle_block();
    if (expected_ranked.size() != 0) begin
      $display("%0t: %0d expected entries never arrived", $time, expected_ranked.size());
    end
    if (mismatch_count == 0 && expected_ranked.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: topk_select_row.f
hw/rtl/tsr_pkg.sv
hw/rtl/tsr_ctrl.sv
hw/rtl/tsr_datapath.sv
hw/rtl/topk_select_row.sv
dv/tb_topk_select_row.sv
